/* hw/rtl/ouart_pkg.sv */
// ============================================================================
// ouart_pkg
// Shared constants, types and helpers for the oversampled UART with its
// receive FIFO.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package ouart_pkg;

    localparam int FIFO_DEPTH = 16;
    localparam int OVERSAMPLE = 3;
    localparam int FRAME_BITS = 10;
    localparam int DATA_BITS  = 8;

    localparam int PTR_W     = $clog2(FIFO_DEPTH);
    localparam int TX_TICK_W = $clog2(OVERSAMPLE + 1);
    localparam int RX_TICK_W = $clog2(OVERSAMPLE + 2);
    localparam int BITS_W    = $clog2(FRAME_BITS + 1);

    localparam logic [7:0] DROP_RESET = 8'hC2;
    localparam logic [7:0] SKIP_RESET = 8'h0A;

    typedef enum logic [1:0] {
        CFG_RX_ENABLE = 2'd0,
        CFG_DROP      = 2'd1,
        CFG_SKIP      = 2'd2
    } t_cfg_index;

    // Everything of one tick that is known at acceptance, waiting for the
    // FIFO head to come out of the memory.
    typedef struct packed {
        logic       tx_level;
        logic       tx_busy;
        logic       tx_accepted;
        logic       not_empty;
        logic       overrun;
        logic       pop;
        logic       fwd;
        logic [7:0] fwd_byte;
    } t_s1;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(FIFO_DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/oversampled_uart_with_rx_fifo.sv */
// ============================================================================
// oversampled_uart_with_rx_fifo
// 8N1 UART at three ticks per bit with a receive ring FIFO held in a
// synchronous memory. Each input transfer is one oversampling tick.
// ============================================================================
//
//  Channel   Direction  Handshake               Payload
//  -------   ---------  ---------------------   ---------------------------------
//  in        input      i_in_valid/o_in_stall   rx_level tx_start tx_byte
//                                               read_req flush
//  out       output     o_out_valid/i_out_stall tx_level tx_busy tx_accepted
//                                               read_valid read_byte
//                                               fifo_not_empty overrun
//  cfg       input      i_cfg_valid/o_cfg_ready index (2 bits), data (8 bits)
//
//  One tick is accepted every cycle while the output does not stall. The
//  accepting edge also registers the FIFO head read together with the tick's
//  known results; the output register is loaded from them once it is free,
//  and the result transfers from there.
//  Reset is synchronous; the FIFO memory needs no clearing pass.
//  A stall on the output holds the two result stages and then stalls input.
//
`timescale 1ns / 1ps
`default_nettype none

module oversampled_uart_with_rx_fifo
    import ouart_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,

    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic       i_rx_level,
    input  wire logic       i_tx_start,
    input  wire logic [7:0] i_tx_byte,
    input  wire logic       i_read_req,
    input  wire logic       i_flush,

    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic            o_tx_level,
    output logic            o_tx_busy,
    output logic            o_tx_accepted,
    output logic            o_read_valid,
    output logic [7:0]      o_read_byte,
    output logic            o_fifo_not_empty,
    output logic            o_overrun,

    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_data
);

    // Configuration registers
    logic       r_rx_enable;
    logic [7:0] r_drop;
    logic [7:0] r_skip;

    // Transmitter
    logic [FRAME_BITS-1:0] r_tx_shift, n_tx_shift;
    logic [TX_TICK_W-1:0]  r_tx_tick, n_tx_tick;
    logic [BITS_W-1:0]     r_tx_bits, n_tx_bits;
    logic                  r_tx_active, n_tx_active;
    logic                  r_tx_line, n_tx_line;

    // Receiver
    logic                  r_rx_active, n_rx_active;
    logic                  r_rx_wait_stop, n_rx_wait_stop;
    logic [RX_TICK_W-1:0]  r_rx_tick, n_rx_tick;
    logic [BITS_W-1:0]     r_rx_bits, n_rx_bits;
    logic [7:0]            r_rx_shift, n_rx_shift;

    // FIFO
    logic [7:0]       fifo_mem [FIFO_DEPTH];
    logic [7:0]       r_rd_data;
    logic [PTR_W-1:0] r_write_ptr, n_write_ptr;
    logic [PTR_W-1:0] r_read_ptr, n_read_ptr;

    // Pipeline
    logic r_s1_valid;
    t_s1  r_s1, n_s1;
    logic s1_move;
    logic in_accept;

    logic                 push_we;
    logic                 rx_done;
    logic [RX_TICK_W-1:0] rx_tick_dec;
    logic [TX_TICK_W-1:0] tx_tick_dec;
    logic [BITS_W-1:0]    tx_bits_dec;
    logic [BITS_W-1:0]    rx_bits_dec;
    logic [BITS_W-1:0]    rx_idx;
    logic [PTR_W-1:0]     wp_inc;
    logic [7:0]           head;

    assign o_cfg_ready = 1'b1;
    assign s1_move     = r_s1_valid && (!o_out_valid || !i_out_stall);
    assign o_in_stall  = r_s1_valid && !s1_move;
    assign in_accept   = i_in_valid && !o_in_stall;

    // ------------------------------------------------------------------
    // Next state of one tick
    // ------------------------------------------------------------------
    always_comb begin
        n_tx_shift     = r_tx_shift;
        n_tx_tick      = r_tx_tick;
        n_tx_bits      = r_tx_bits;
        n_tx_active    = r_tx_active;
        n_tx_line      = r_tx_line;
        n_rx_active    = r_rx_active;
        n_rx_wait_stop = r_rx_wait_stop;
        n_rx_tick      = r_rx_tick;
        n_rx_bits      = r_rx_bits;
        n_rx_shift     = r_rx_shift;
        n_write_ptr    = r_write_ptr;
        n_read_ptr     = r_read_ptr;
        n_s1           = '0;
        push_we        = 1'b0;
        rx_done        = 1'b0;

        tx_tick_dec = (r_tx_tick != '0) ? r_tx_tick - 1'b1 : r_tx_tick;
        tx_bits_dec = (r_tx_bits != '0) ? r_tx_bits - 1'b1 : r_tx_bits;
        rx_tick_dec = (r_rx_tick != '0) ? r_rx_tick - 1'b1 : r_rx_tick;
        rx_bits_dec = (r_rx_bits != '0) ? r_rx_bits - 1'b1 : r_rx_bits;
        rx_idx      = BITS_W'(FRAME_BITS) - r_rx_bits;
        wp_inc      = ptr_next(r_write_ptr);

        // Transmitter
        if (r_tx_active) begin
            n_tx_tick = tx_tick_dec;
            if (tx_tick_dec == '0) begin
                n_tx_line  = r_tx_shift[0];
                n_tx_shift = {1'b1, r_tx_shift[FRAME_BITS-1:1]};
                n_tx_tick  = TX_TICK_W'(OVERSAMPLE);
                n_tx_bits  = tx_bits_dec;
                if (tx_bits_dec == '0) begin
                    n_tx_active = 1'b0;
                    n_tx_line   = 1'b1;
                end
            end
        end
        if (i_tx_start && !r_tx_active) begin
            n_tx_tick       = TX_TICK_W'(OVERSAMPLE);
            n_tx_bits       = BITS_W'(FRAME_BITS);
            n_tx_shift      = {1'b1, i_tx_byte, 1'b0};
            n_tx_active     = 1'b1;
            n_s1.tx_accepted = 1'b1;
        end

        // Receiver
        if (r_rx_enable) begin
            if (r_rx_wait_stop) begin
                n_rx_tick = rx_tick_dec;
                if (rx_tick_dec == '0) begin
                    n_rx_wait_stop = 1'b0;
                    n_rx_active    = 1'b0;
                    rx_done        = r_rx_shift != r_drop;
                end
            end else if (!r_rx_active) begin
                if (!i_rx_level) begin
                    n_rx_active = 1'b1;
                    n_rx_shift  = '0;
                    n_rx_tick   = RX_TICK_W'(OVERSAMPLE + 1);
                    n_rx_bits   = BITS_W'(FRAME_BITS);
                end
            end else begin
                n_rx_tick = rx_tick_dec;
                if (rx_tick_dec == '0) begin
                    n_rx_tick = RX_TICK_W'(OVERSAMPLE);
                    if (i_rx_level && rx_idx < BITS_W'(DATA_BITS)) begin
                        n_rx_shift[rx_idx[2:0]] = 1'b1;
                    end
                    n_rx_bits = rx_bits_dec;
                    if (rx_bits_dec == '0) begin
                        n_rx_wait_stop = 1'b1;
                    end
                end
            end
        end

        // Push; a full FIFO drops the byte and flags overrun.
        if (rx_done) begin
            if (wp_inc == r_read_ptr) begin
                n_s1.overrun = 1'b1;
            end else begin
                push_we     = 1'b1;
                n_write_ptr = wp_inc;
            end
        end

        // Pop. When the FIFO was empty the head is the byte pushed this tick,
        // which the memory cannot return yet, so it is forwarded.
        if (i_read_req && r_read_ptr != n_write_ptr) begin
            n_s1.pop      = 1'b1;
            n_s1.fwd      = push_we && (r_write_ptr == r_read_ptr);
            n_s1.fwd_byte = r_rx_shift;
            n_read_ptr    = ptr_next(r_read_ptr);
        end

        if (i_flush) begin
            n_write_ptr = '0;
            n_read_ptr  = '0;
        end

        n_s1.tx_level  = n_tx_line;
        n_s1.tx_busy   = n_tx_active;
        n_s1.not_empty = n_read_ptr != n_write_ptr;
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_enable <= 1'b1;
            r_drop      <= DROP_RESET;
            r_skip      <= SKIP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_RX_ENABLE: r_rx_enable <= i_cfg_data[0];
                CFG_DROP:      r_drop      <= i_cfg_data;
                CFG_SKIP:      r_skip      <= i_cfg_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_shift     <= '1;
            r_tx_tick      <= '0;
            r_tx_bits      <= '0;
            r_tx_active    <= 1'b0;
            r_tx_line      <= 1'b1;
            r_rx_active    <= 1'b0;
            r_rx_wait_stop <= 1'b0;
            r_rx_tick      <= '0;
            r_rx_bits      <= '0;
            r_rx_shift     <= '0;
            r_write_ptr    <= '0;
            r_read_ptr     <= '0;
        end else if (in_accept) begin
            r_tx_shift     <= n_tx_shift;
            r_tx_tick      <= n_tx_tick;
            r_tx_bits      <= n_tx_bits;
            r_tx_active    <= n_tx_active;
            r_tx_line      <= n_tx_line;
            r_rx_active    <= n_rx_active;
            r_rx_wait_stop <= n_rx_wait_stop;
            r_rx_tick      <= n_rx_tick;
            r_rx_bits      <= n_rx_bits;
            r_rx_shift     <= n_rx_shift;
            r_write_ptr    <= n_write_ptr;
            r_read_ptr     <= n_read_ptr;
        end
    end

    // FIFO memory: one write port, one registered read port at the head.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            if (push_we) begin
                fifo_mem[r_write_ptr] <= r_rx_shift;
            end
            r_rd_data <= fifo_mem[r_read_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1 <= n_s1;
        end
    end

    assign head = r_s1.fwd ? r_s1.fwd_byte : r_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (s1_move) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            o_tx_level       <= r_s1.tx_level;
            o_tx_busy        <= r_s1.tx_busy;
            o_tx_accepted    <= r_s1.tx_accepted;
            o_fifo_not_empty <= r_s1.not_empty;
            o_overrun        <= r_s1.overrun;
            o_read_valid     <= r_s1.pop && (head != r_skip);
            o_read_byte      <= (r_s1.pop && (head != r_skip)) ? head : 8'h00;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_byte_zero_when_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_read_valid |-> o_read_byte == 8'h00)
        else $error("read_byte nonzero without read_valid");

    a_load_makes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_tx_accepted |-> o_tx_busy)
        else $error("accepted load did not start the transmitter");

    a_idle_line_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_tx_busy |-> o_tx_level)
        else $error("transmit line low while transmitter idle");

    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_move |=> r_s1_valid && $stable(r_rd_data))
        else $error("waiting tick lost its head data");

endmodule

`default_nettype wire

/* verif/testbench.sv */
// ============================================================================
// Testbench for oversampled_uart_with_rx_fifo
// Drives oversampling ticks through the input channel and checks every output
// transfer against a cycle-free model of the transmitter, the receiver and the
// receive FIFO. A short table of directed ticks comes first. After it come
// UART frames on the receive line, mostly well formed with random content and
// some broken or noisy, under several register settings, with random gaps on
// both channels and one long output hold-off.
// ============================================================================
`timescale 1ns / 1ps

module testbench
    import ouart_pkg::*;
();

    localparam int unsigned CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic       rx;
        logic       start;
        logic [7:0] tbyte;
        logic       rd;
        logic       fl;
    } t_tick;

    typedef struct packed {
        logic       tx_level;
        logic       tx_busy;
        logic       tx_acc;
        logic       rd_valid;
        logic [7:0] rd_byte;
        logic       not_empty;
        logic       overrun;
    } t_uart_out;

    typedef struct packed {
        t_tick     tk;
        logic      typed;
        t_uart_out want;
    } t_dir_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    logic       i_rx_level = 1'b1;
    logic       i_tx_start = 1'b0;
    logic [7:0] i_tx_byte = 8'h00;
    logic       i_read_req = 1'b0;
    logic       i_flush = 1'b0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    logic       o_tx_level;
    logic       o_tx_busy;
    logic       o_tx_accepted;
    logic       o_read_valid;
    logic [7:0] o_read_byte;
    logic       o_fifo_not_empty;
    logic       o_overrun;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_index = 2'd0;
    logic [7:0] i_cfg_data = 8'h00;

    oversampled_uart_with_rx_fifo u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_rx_level       (i_rx_level),
        .i_tx_start       (i_tx_start),
        .i_tx_byte        (i_tx_byte),
        .i_read_req       (i_read_req),
        .i_flush          (i_flush),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_tx_level       (o_tx_level),
        .o_tx_busy        (o_tx_busy),
        .o_tx_accepted    (o_tx_accepted),
        .o_read_valid     (o_read_valid),
        .o_read_byte      (o_read_byte),
        .o_fifo_not_empty (o_fifo_not_empty),
        .o_overrun        (o_overrun),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // Model state: registers and the UART/FIFO state after the last tick.
    logic                 m_rx_en;
    logic [7:0]           m_drop;
    logic [7:0]           m_skip;
    logic [9:0]           m_tx_shift;
    logic [TX_TICK_W-1:0] m_tx_ticks;
    logic [BITS_W-1:0]    m_tx_bits;
    logic                 m_tx_active;
    logic                 m_tx_line;
    logic                 m_rx_active;
    logic                 m_rx_wait;
    logic [RX_TICK_W-1:0] m_rx_ticks;
    logic [BITS_W-1:0]    m_rx_bits;
    logic [7:0]           m_rx_shift;
    logic [7:0]           m_fifo [FIFO_DEPTH];
    logic [PTR_W-1:0]     m_wptr;
    logic [PTR_W-1:0]     m_rptr;

    t_uart_out pending_outputs[$];
    t_tick     line_ticks[$];
    t_uart_out head_want;

    int unsigned cycle_count = 0;
    int unsigned fail_count = 0;
    int unsigned ticks_sent = 0;
    int unsigned results_checked = 0;
    int unsigned bytes_read = 0;
    int unsigned overruns = 0;
    int unsigned tx_loads = 0;

    // Stimulus knobs, in percent per tick.
    int unsigned tx_pct = 10;
    int unsigned rd_pct = 0;
    int unsigned fl_pct = 0;
    bit          quiet = 1'b0;
    bit          holdoff_go = 1'b0;
    int unsigned holdoff_len = 150;

    // Directed ticks right after reset. The transmitter is loaded with 0xFF and
    // then asked again while busy; rows with a typed result are the obvious ones.
    localparam int DIR_ROWS = 14;
    t_dir_row dir_table [DIR_ROWS] = '{
        '{'{1, 0, 8'h00, 0, 0}, 1, '{1, 0, 0, 0, 8'h00, 0, 0}},
        '{'{1, 0, 8'h00, 1, 0}, 1, '{1, 0, 0, 0, 8'h00, 0, 0}},
        '{'{1, 0, 8'h00, 0, 1}, 1, '{1, 0, 0, 0, 8'h00, 0, 0}},
        '{'{1, 0, 8'h00, 1, 1}, 1, '{1, 0, 0, 0, 8'h00, 0, 0}},
        '{'{1, 1, 8'hFF, 0, 0}, 1, '{1, 1, 1, 0, 8'h00, 0, 0}},
        '{'{1, 1, 8'h00, 0, 0}, 1, '{1, 1, 0, 0, 8'h00, 0, 0}},
        '{'{1, 1, 8'hA5, 1, 0}, 0, '0},
        '{'{1, 0, 8'h5A, 0, 0}, 0, '0},
        '{'{1, 1, 8'h0F, 0, 1}, 0, '0},
        '{'{1, 0, 8'hF0, 1, 1}, 0, '0},
        '{'{1, 1, 8'h80, 0, 0}, 0, '0},
        '{'{1, 0, 8'h01, 1, 0}, 0, '0},
        '{'{1, 1, 8'hFF, 0, 0}, 0, '0},
        '{'{1, 0, 8'h00, 0, 0}, 0, '0}
    };

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
                $display("testbench failed");
                $finish;
            end
        end
    end

    // Output stall: short random stalls, plus one long hold-off on request.
    initial begin
        forever begin
            @(posedge i_clk);
            if (holdoff_go) begin
                i_out_stall <= 1'b1;
                repeat (holdoff_len) @(posedge i_clk);
                holdoff_go = 1'b0;
            end
            i_out_stall <= !quiet && ($urandom_range(99) < 7);
        end
    end

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    task automatic uart_model_reset();
        m_rx_en     = 1'b1;
        m_drop      = DROP_RESET;
        m_skip      = SKIP_RESET;
        m_tx_shift  = '1;
        m_tx_ticks  = '0;
        m_tx_bits   = '0;
        m_tx_active = 1'b0;
        m_tx_line   = 1'b1;
        m_rx_active = 1'b0;
        m_rx_wait   = 1'b0;
        m_rx_ticks  = '0;
        m_rx_bits   = '0;
        m_rx_shift  = '0;
        m_wptr      = '0;
        m_rptr      = '0;
        foreach (m_fifo[i]) m_fifo[i] = '0;
    endtask

    // Advances the model by one tick and returns the outputs after it.
    function automatic t_uart_out next_uart_outputs(input t_tick t);
        t_uart_out        r;
        logic             was_active;
        logic [PTR_W-1:0] nw;
        logic [7:0]       head;
        int               idx;
        r = '0;
        was_active = m_tx_active;

        if (m_tx_active) begin
            if (m_tx_ticks > 0) m_tx_ticks--;
            if (m_tx_ticks == 0) begin
                m_tx_line  = m_tx_shift[0];
                m_tx_shift = {1'b1, m_tx_shift[9:1]};
                m_tx_ticks = TX_TICK_W'(OVERSAMPLE);
                if (m_tx_bits > 0) m_tx_bits--;
                if (m_tx_bits == 0) begin
                    m_tx_active = 1'b0;
                    m_tx_line   = 1'b1;
                end
            end
        end
        // The load sees the busy flag from the start of the tick.
        if (t.start && !was_active) begin
            m_tx_ticks  = TX_TICK_W'(OVERSAMPLE);
            m_tx_bits   = BITS_W'(FRAME_BITS);
            m_tx_shift  = {1'b1, t.tbyte, 1'b0};
            m_tx_active = 1'b1;
            r.tx_acc    = 1'b1;
        end

        if (m_rx_en) begin
            if (m_rx_wait) begin
                if (m_rx_ticks > 0) m_rx_ticks--;
                if (m_rx_ticks == 0) begin
                    m_rx_wait   = 1'b0;
                    m_rx_active = 1'b0;
                    if (m_rx_shift != m_drop) begin
                        nw = wrap_inc(m_wptr);
                        if (nw == m_rptr) begin
                            r.overrun = 1'b1;
                        end else begin
                            m_fifo[m_wptr] = m_rx_shift;
                            m_wptr = nw;
                        end
                    end
                end
            end else if (!m_rx_active) begin
                if (!t.rx) begin
                    m_rx_active = 1'b1;
                    m_rx_shift  = '0;
                    m_rx_ticks  = RX_TICK_W'(OVERSAMPLE + 1);
                    m_rx_bits   = BITS_W'(FRAME_BITS);
                end
            end else begin
                if (m_rx_ticks > 0) m_rx_ticks--;
                if (m_rx_ticks == 0) begin
                    idx = FRAME_BITS - int'(m_rx_bits);
                    m_rx_ticks = RX_TICK_W'(OVERSAMPLE);
                    if (t.rx && idx < DATA_BITS) m_rx_shift[idx] = 1'b1;
                    if (m_rx_bits > 0) m_rx_bits--;
                    if (m_rx_bits == 0) m_rx_wait = 1'b1;
                end
            end
        end

        // A byte pushed in this tick can already be popped.
        if (t.rd && m_rptr != m_wptr) begin
            head = m_fifo[m_rptr];
            m_rptr = wrap_inc(m_rptr);
            if (head != m_skip) begin
                r.rd_valid = 1'b1;
                r.rd_byte  = head;
            end
        end
        if (t.fl) begin
            m_wptr = '0;
            m_rptr = '0;
        end

        r.tx_level  = m_tx_line;
        r.tx_busy   = m_tx_active;
        r.not_empty = (m_rptr != m_wptr);
        return r;
    endfunction

    function automatic t_tick rand_tick(input logic rx, input bit force_rd);
        t_tick t;
        t.rx    = rx;
        t.start = ($urandom_range(99) < tx_pct);
        t.tbyte = 8'($urandom);
        t.rd    = force_rd || ($urandom_range(99) < rd_pct);
        t.fl    = ($urandom_range(99) < fl_pct);
        return t;
    endfunction

    // One frame on the receive line: start bit, data LSB first, stop bit, then
    // an idle gap. A broken frame has uneven bit lengths and may glitch low.
    task automatic add_frame(input logic [7:0] data, input int gap, input bit gap_rd,
                             input bit broken);
        logic [9:0] bits;
        int         len;
        t_tick      t;
        bits = {1'b1, data, 1'b0};
        for (int i = 0; i < FRAME_BITS; i++) begin
            len = broken ? $urandom_range(2, 4) : OVERSAMPLE;
            for (int j = 0; j < len; j++) line_ticks.push_back(rand_tick(bits[i], 1'b0));
        end
        for (int i = 0; i < gap; i++) begin
            t = rand_tick(1'b1, gap_rd);
            if (broken && i == 1 && $urandom_range(1)) t.rx = 1'b0;
            line_ticks.push_back(t);
        end
    endtask

    task automatic add_idle(input int n, input bit rd, input bit fl);
        t_tick t;
        for (int i = 0; i < n; i++) begin
            t = rand_tick(1'b1, rd);
            t.fl = fl;
            line_ticks.push_back(t);
        end
    endtask

    task automatic add_noise(input int n);
        for (int i = 0; i < n; i++) line_ticks.push_back(rand_tick($urandom_range(1), 1'b0));
    endtask

    function automatic logic [7:0] pick_data();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 15) return m_drop;
        if (r < 30) return m_skip;
        return 8'($urandom);
    endfunction

    task automatic random_frames(input int n);
        bit broken;
        for (int i = 0; i < n; i++) begin
            broken = ($urandom_range(99) < 15);
            add_frame(pick_data(), broken ? $urandom_range(0, 4) : $urandom_range(5, 9),
                      1'b0, broken);
        end
    endtask

    // Called just after a rising edge; returns just after the edge that took
    // the tick.
    task automatic send_tick(input t_tick t, input bit typed, input t_uart_out want);
        t_uart_out pred;
        if (!quiet && $urandom_range(99) < 5) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_level <= t.rx;
        i_tx_start <= t.start;
        i_tx_byte  <= t.tbyte;
        i_read_req <= t.rd;
        i_flush    <= t.fl;
        do @(posedge i_clk); while (o_in_stall);
        pred = next_uart_outputs(t);
        if (typed) pred = want;
        pending_outputs.push_back(pred);
        ticks_sent++;
        if (pred.rd_valid) bytes_read++;
        if (pred.overrun) overruns++;
        if (pred.tx_acc) tx_loads++;
    endtask

    task automatic play_ticks(input int n);
        for (int k = 0; k < n && line_ticks.size() > 0; k++) begin
            send_tick(line_ticks.pop_front(), 1'b0, '0);
        end
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Waits for every expected transfer, then for the output pipeline to empty.
    task automatic settle();
        while (pending_outputs.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [7:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_RX_ENABLE: m_rx_en = val[0];
            CFG_DROP:      m_drop = val;
            CFG_SKIP:      m_skip = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_outputs.size() == 0) begin
                $display("%0t: output transfer with nothing expected", $time);
                fail_count++;
            end else begin
                head_want = pending_outputs.pop_front();
                results_checked++;
                check_field("tx_level", head_want.tx_level, o_tx_level);
                check_field("tx_busy", head_want.tx_busy, o_tx_busy);
                check_field("tx_accepted", head_want.tx_acc, o_tx_accepted);
                check_field("read_valid", head_want.rd_valid, o_read_valid);
                check_field("read_byte", head_want.rd_byte, o_read_byte);
                check_field("fifo_not_empty", head_want.not_empty, o_fifo_not_empty);
                check_field("overrun", head_want.overrun, o_overrun);
            end
        end
    end

    initial begin : stimulus
        t_tick held[$];

        uart_model_reset();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_table[i]) send_tick(dir_table[i].tk, dir_table[i].typed, dir_table[i].want);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        settle();

        // Reset settings: extreme bytes, a dropped byte, a skipped head, a pop in
        // the push tick, read with flush, and flush alone.
        add_idle(12, 1'b0, 1'b0);
        add_frame(8'h00, 6, 1'b0, 1'b0);
        add_frame(8'hFF, 6, 1'b0, 1'b0);
        add_frame(DROP_RESET, 6, 1'b0, 1'b0);
        add_frame(SKIP_RESET, 6, 1'b0, 1'b0);
        add_idle(5, 1'b1, 1'b0);
        add_frame(8'h5A, 6, 1'b1, 1'b0);
        add_frame(8'h33, 5, 1'b0, 1'b0);
        add_idle(1, 1'b1, 1'b1);
        add_frame(8'h44, 5, 1'b0, 1'b0);
        add_idle(1, 1'b0, 1'b1);
        add_idle(2, 1'b1, 1'b0);
        play_ticks(line_ticks.size());
        settle();

        // The receiver is switched off in the middle of a frame; the line noise
        // meanwhile must not disturb it.
        add_frame(8'h96, 6, 1'b0, 1'b0);
        play_ticks(14);
        held = line_ticks;
        line_ticks = {};
        settle();
        write_reg(CFG_RX_ENABLE, 8'h00);
        add_noise(20);
        play_ticks(line_ticks.size());
        settle();
        write_reg(CFG_RX_ENABLE, 8'h01);
        line_ticks = held;
        add_idle(3, 1'b1, 1'b0);
        play_ticks(line_ticks.size());
        settle();

        // Random frames with a long output hold-off that backs up the input.
        write_reg(CFG_DROP, 8'h00);
        write_reg(CFG_SKIP, 8'hFF);
        rd_pct = 35;
        fl_pct = 1;
        holdoff_len = 150;
        holdoff_go = 1'b1;
        random_frames(6);
        play_ticks(line_ticks.size());
        settle();

        // No reads until the FIFO is full and overruns, then drain it.
        write_reg(CFG_DROP, 8'hFF);
        write_reg(CFG_SKIP, 8'h00);
        rd_pct = 0;
        fl_pct = 0;
        quiet = 1'b1;
        for (int i = 0; i < FIFO_DEPTH + 1; i++) begin
            add_frame(($urandom_range(99) < 20) ? 8'h00 : 8'($urandom_range(254)), 5,
                      1'b0, 1'b0);
        end
        add_idle(FIFO_DEPTH + 2, 1'b1, 1'b0);
        play_ticks(line_ticks.size());
        settle();
        quiet = 1'b0;

        write_reg(CFG_DROP, 8'($urandom));
        write_reg(CFG_SKIP, 8'($urandom));
        rd_pct = 30;
        fl_pct = 1;
        random_frames(4);
        add_noise(30);
        random_frames(2);
        play_ticks(line_ticks.size());
        settle();

        write_reg(CFG_RX_ENABLE, 8'h00);
        rd_pct = 40;
        add_noise(40);
        play_ticks(line_ticks.size());
        settle();
        write_reg(CFG_RX_ENABLE, 8'h01);
        repeat (8) @(posedge i_clk);

        $display("Sent %0d ticks and checked %0d output transfers.", ticks_sent,
                 results_checked);
        $display("Bytes read: %0d, overruns: %0d, transmitter loads: %0d.", bytes_read,
                 overruns, tx_loads);
        if (fail_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
